>>> src/swt_pkg.sv
// Shared types, character codes and helpers for the shell word tokenizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package swt_pkg;

  localparam logic [7:0] CH_SQ = 8'h27;
  localparam logic [7:0] CH_DQ = 8'h22;
  localparam logic [7:0] CH_BS = 8'h5C;
  localparam logic [7:0] CH_SP = 8'h20;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PLAIN = 2'd1,
    MODE_SQ    = 2'd2,
    MODE_DQ    = 2'd3
  } mode_t;

  typedef struct packed {
    logic       action;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] out_char;
    logic       token_end;
    logic       line_done;
    logic       error;
    logic       last;
  } out_item_t;

  // One queued job: the results caused by one input item
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } job_t;

  localparam out_item_t NO_RESULT = '{default: 1'b0};

  function automatic out_item_t char_result(input logic [7:0] c);
    out_item_t r;
    r          = NO_RESULT;
    r.has_char = 1'b1;
    r.out_char = c;
    return r;
  endfunction

endpackage

>>> src/swt_front.sv
// Front end: takes one character transaction a cycle while job_ready is high
// and tracks quoting; each item becomes a job of 0-2 results. Uses swt_pkg.
`timescale 1ns / 1ps

module swt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  swt_pkg::in_item_t in_data,
  output logic             job_valid,
  input  logic             job_ready,
  output swt_pkg::job_t    job
);
  import swt_pkg::*;

  mode_t mode, mode_next;
  logic  escape_pending, escape_pending_next;
  logic  accept;
  logic  any_result;
  logic  [7:0] c;

  assign c        = in_data.ch;
  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      escape_pending <= 1'b0;
    end else if (accept) begin
      mode           <= mode_next;
      escape_pending <= escape_pending_next;
    end
  end

  // Next state
  always_comb begin
    mode_next           = mode;
    escape_pending_next = escape_pending;
    if (in_data.action) begin
      mode_next           = MODE_IDLE;
      escape_pending_next = 1'b0;
    end else begin
      case (mode)
        MODE_IDLE: begin
          if (c == CH_SQ) begin
            mode_next = MODE_SQ;
          end else if (c == CH_DQ) begin
            mode_next = MODE_DQ;
          end else if (c != CH_SP) begin
            mode_next           = MODE_PLAIN;
            escape_pending_next = (c == CH_BS);
          end
        end
        MODE_PLAIN: begin
          if (escape_pending) begin
            escape_pending_next = 1'b0;
          end else if (c == CH_BS) begin
            escape_pending_next = 1'b1;
          end else if (c == CH_SP) begin
            mode_next = MODE_IDLE;
          end
        end
        MODE_SQ: begin
          if (c == CH_SQ) mode_next = MODE_IDLE;
        end
        MODE_DQ: begin
          if (escape_pending) begin
            escape_pending_next = (c == CH_BS);
          end else if (c == CH_BS) begin
            escape_pending_next = 1'b1;
          end else if (c == CH_DQ) begin
            mode_next = MODE_IDLE;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase
    end
  end

  // Results of this item
  always_comb begin
    any_result = 1'b0;
    job        = '{two: 1'b0, first: NO_RESULT, second: NO_RESULT};
    if (in_data.action) begin
      any_result = 1'b1;
      case (mode)
        MODE_PLAIN: begin
          if (escape_pending) begin
            job.two              = 1'b1;
            job.first            = char_result(CH_BS);
            job.second.token_end = 1'b1;
            job.second.line_done = 1'b1;
          end else begin
            job.first.token_end = 1'b1;
            job.first.line_done = 1'b1;
          end
        end
        MODE_SQ, MODE_DQ: begin
          // open quote: flag the line, drop any pending backslash
          job.first.line_done = 1'b1;
          job.first.error     = 1'b1;
        end
        default: begin
          job.first.line_done = 1'b1;
        end
      endcase
    end else begin
      case (mode)
        MODE_IDLE: begin
          if (c != CH_SP && c != CH_SQ && c != CH_DQ && c != CH_BS) begin
            any_result = 1'b1;
            job.first  = char_result(c);
          end
        end
        MODE_PLAIN: begin
          if (escape_pending) begin
            any_result = 1'b1;
            job.first  = char_result(c);
          end else if (c == CH_SP) begin
            any_result          = 1'b1;
            job.first.token_end = 1'b1;
          end else if (c != CH_BS) begin
            any_result = 1'b1;
            job.first  = char_result(c);
          end
        end
        MODE_SQ: begin
          any_result = 1'b1;
          if (c == CH_SQ) job.first.token_end = 1'b1;
          else            job.first = char_result(c);
        end
        MODE_DQ: begin
          if (escape_pending) begin
            any_result = 1'b1;
            if (c == CH_DQ) begin
              job.first = char_result(CH_DQ);
            end else if (c == CH_BS) begin
              job.first = char_result(CH_BS);
            end else begin
              job.two    = 1'b1;
              job.first  = char_result(CH_BS);
              job.second = char_result(c);
            end
          end else if (c == CH_DQ) begin
            any_result          = 1'b1;
            job.first.token_end = 1'b1;
          end else if (c != CH_BS) begin
            any_result = 1'b1;
            job.first  = char_result(c);
          end
        end
        default: begin
          any_result = 1'b0;
        end
      endcase
    end
    // mark the final result of the item
    if (job.two) job.second.last = 1'b1;
    else         job.first.last  = 1'b1;
  end

  assign job_valid = in_valid && any_result;

endmodule

>>> src/swt_queue.sv
// Short job queue between the front and back ends, held in flip-flops.
// Depends on swt_pkg for the job type and depth.
`timescale 1ns / 1ps

module swt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  swt_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output swt_pkg::job_t  head
);
  import swt_pkg::*;

  job_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule

>>> src/swt_back.sv
// Back end: drains jobs from the queue and presents their results one per
// transaction through an output register. Depends on swt_pkg.
`timescale 1ns / 1ps

module swt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_avail,
  input  swt_pkg::job_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output swt_pkg::out_item_t out_data
);
  import swt_pkg::*;

  logic      second_pending;
  out_item_t second;
  logic      load;

  assign load = !out_valid || out_ready;
  assign pop  = load && !second_pending && job_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      second_pending <= 1'b0;
    end else if (load) begin
      if (second_pending) begin
        out_valid      <= 1'b1;
        second_pending <= 1'b0;
      end else if (job_avail) begin
        out_valid      <= 1'b1;
        second_pending <= head.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: hold the second result of a pair until its slot comes up
  always_ff @(posedge clk) begin
    if (load) begin
      if (second_pending) begin
        out_data <= second;
      end else if (job_avail) begin
        out_data <= head.first;
        second   <= head.second;
      end
    end
  end

endmodule

>>> src/shell_word_tokenizer.sv
// Top level of the shell word tokenizer: front end, job queue and back end.
// Depends on swt_pkg, swt_front, swt_queue and swt_back.
`timescale 1ns / 1ps

// Takes one line character (or end-of-line mark) per transaction and emits
// word characters, word ends and a line-done result, with error set when a
// quote is left open. An input item is taken every cycle while the four-entry
// job queue has room; the quoting state is a register in the front end that is
// updated on each accepted item. Results leave one per cycle from the output
// register while out_ready is high, so an item that yields two results (an
// escaped byte in double quotes, or a trailing backslash at end of line) takes
// two output transactions; the queue absorbs such bursts, and each result
// passes through a queue slot register and then the output register.
module shell_word_tokenizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  swt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output swt_pkg::out_item_t out_data
);
  import swt_pkg::*;

  job_t job, head;
  logic job_valid, full, empty, pop, push;

  assign push = job_valid && !full;

  swt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_ready (!full),
    .job       (job)
  );

  swt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  swt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (!empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sim/tb_shell_word_tokenizer.sv
// Testbench for shell_word_tokenizer: directed lines, random lines and noise,
// checked against an in-bench tokenizer model. Depends on swt_pkg and the RTL.
`timescale 1ns / 1ps

module tb_shell_word_tokenizer;
  import swt_pkg::*;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Word results still owed by the block, oldest first
  out_item_t expected_results[$];

  // Tokenizer state as the model sees it
  mode_t     tok_mode   = MODE_IDLE;
  logic      tok_escape = 1'b0;

  int        mismatches = 0;
  int        items_sent = 0;
  logic      steady     = 1'b0;   // 1 = neither side idles

  always #5 clk = ~clk;

  shell_word_tokenizer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  function automatic out_item_t word_result(logic has, logic [7:0] c, logic te, logic ld,
                                            logic err);
    out_item_t r;
    r           = '0;
    r.has_char  = has;
    r.out_char  = has ? c : 8'h00;
    r.token_end = te;
    r.line_done = ld;
    r.error     = err;
    return r;
  endfunction

  // Advance the model by one accepted item and queue the results it owes
  task automatic predict_tokens(input in_item_t it);
    out_item_t  burst[$];
    logic [7:0] c;
    c = it.ch;
    if (it.action) begin
      case (tok_mode)
        MODE_PLAIN: begin
          if (tok_escape) burst.push_back(word_result(1'b1, CH_BS, 1'b0, 1'b0, 1'b0));
          burst.push_back(word_result(1'b0, 8'h00, 1'b1, 1'b1, 1'b0));
        end
        MODE_SQ, MODE_DQ: burst.push_back(word_result(1'b0, 8'h00, 1'b0, 1'b1, 1'b1));
        default: burst.push_back(word_result(1'b0, 8'h00, 1'b0, 1'b1, 1'b0));
      endcase
      tok_mode   = MODE_IDLE;
      tok_escape = 1'b0;
    end else begin
      case (tok_mode)
        MODE_IDLE: begin
          // a space between words is dropped
          if (c == CH_SQ) tok_mode = MODE_SQ;
          else if (c == CH_DQ) tok_mode = MODE_DQ;
          else if (c != CH_SP) begin
            tok_mode = MODE_PLAIN;
            if (c == CH_BS) tok_escape = 1'b1;
            else burst.push_back(word_result(1'b1, c, 1'b0, 1'b0, 1'b0));
          end
        end
        MODE_PLAIN: begin
          if (tok_escape) begin
            tok_escape = 1'b0;
            burst.push_back(word_result(1'b1, c, 1'b0, 1'b0, 1'b0));
          end else if (c == CH_BS) begin
            tok_escape = 1'b1;
          end else if (c == CH_SP) begin
            burst.push_back(word_result(1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
            tok_mode = MODE_IDLE;
          end else begin
            burst.push_back(word_result(1'b1, c, 1'b0, 1'b0, 1'b0));
          end
        end
        MODE_SQ: begin
          if (c == CH_SQ) begin
            burst.push_back(word_result(1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
            tok_mode = MODE_IDLE;
          end else begin
            burst.push_back(word_result(1'b1, c, 1'b0, 1'b0, 1'b0));
          end
        end
        default: begin
          if (tok_escape) begin
            if (c == CH_DQ) begin
              tok_escape = 1'b0;
              burst.push_back(word_result(1'b1, CH_DQ, 1'b0, 1'b0, 1'b0));
            end else if (c == CH_BS) begin
              // one backslash out, the second one stays pending
              burst.push_back(word_result(1'b1, CH_BS, 1'b0, 1'b0, 1'b0));
            end else begin
              tok_escape = 1'b0;
              burst.push_back(word_result(1'b1, CH_BS, 1'b0, 1'b0, 1'b0));
              burst.push_back(word_result(1'b1, c, 1'b0, 1'b0, 1'b0));
            end
          end else if (c == CH_BS) begin
            tok_escape = 1'b1;
          end else if (c == CH_DQ) begin
            burst.push_back(word_result(1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
            tok_mode = MODE_IDLE;
          end else begin
            burst.push_back(word_result(1'b1, c, 1'b0, 1'b0, 1'b0));
          end
        end
      endcase
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) expected_results.push_back(burst[i]);
  endtask

  // Present one item, hold it until the transaction completes, then predict
  task automatic send_item(input in_item_t it);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tokens(it);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(in_item_t'{action: 1'b0, ch: c});
  endtask

  task automatic send_eol();
    send_item(in_item_t'{action: 1'b1, ch: 8'($urandom_range(0, 255))});
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Biased towards the bytes that steer the quoting logic
  function automatic logic [7:0] word_byte();
    case ($urandom_range(0, 9))
      0:       return CH_BS;
      1:       return CH_SQ;
      2:       return CH_DQ;
      3, 4:    return 8'($urandom_range(0, 255));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // A line of mostly well-formed words; some quotes are left open
  task automatic send_random_line();
    int         n_words;
    int         len;
    logic [7:0] q;
    logic [7:0] b;
    n_words = $urandom_range(1, 5);
    for (int w = 0; w < n_words; w++) begin
      repeat ($urandom_range(0, 2)) send_char(CH_SP);
      len = $urandom_range(0, 6);
      case ($urandom_range(0, 3))
        0, 1: begin
          for (int i = 0; i <= len; i++) begin
            if ($urandom_range(0, 5) == 0) begin
              send_char(CH_BS);
              send_char($urandom_range(0, 1) ? CH_SP : word_byte());
            end else begin
              send_char(word_byte());
            end
          end
        end
        default: begin
          q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
          send_char(q);
          for (int i = 0; i < len; i++) begin
            b = word_byte();
            if (b == q) b = 8'h71;
            if (q == CH_DQ && $urandom_range(0, 3) == 0) begin
              send_char(CH_BS);
              case ($urandom_range(0, 2))
                0:       b = CH_DQ;
                1:       b = CH_BS;
                default: b = b;
              endcase
            end
            send_char(b);
          end
          if ($urandom_range(0, 9) != 0) send_char(q);
        end
      endcase
    end
    if ($urandom_range(0, 7) == 0) send_char(CH_BS);
    send_eol();
  endtask

  task automatic test_directed();
    // escaped space and a literal quote inside an unquoted word
    send_text("\\ a\"b");
    send_eol();
    // trailing backslash at end of line
    send_text("\\");
    send_eol();
    // escaped quote, double backslash, escaped other byte, open quote with escape pending
    send_text("\"\\\"\\\\q\\");
    send_eol();
    // zero and all-ones bytes; a closing quote followed straight by a new word
    send_char(CH_SQ);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_SQ);
    send_char(8'h00);
    send_eol();
    // empty double-quoted word, then a single quote left open
    send_text("\"\"'");
    send_eol();
    // end of line while idle
    send_eol();
  endtask

  task automatic test_random_lines(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) send_random_line();
  endtask

  task automatic test_back_to_back(input int count);
    steady = 1'b1;
    test_random_lines(count);
    steady = 1'b0;
  endtask

  task automatic test_noise(input int count);
    in_item_t it;
    repeat (count) begin
      it.action = ($urandom_range(0, 7) == 0);
      it.ch     = ($urandom_range(0, 3) == 0) ? CH_SP : word_byte();
      send_item(it);
    end
  endtask

  task automatic test_drain();
    in_valid <= 1'b0;
    for (int i = 0; i < 20000 && expected_results.size() != 0; i++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived, oldest has_char=%b char=%h", $time,
               expected_results.size(), expected_results[0].has_char,
               expected_results[0].out_char);
      mismatches += expected_results.size();
    end
  endtask

  // Take results with random back-pressure and match them in order
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: expected nothing, got has_char=%b char=%h end=%b done=%b err=%b last=%b",
                 $time, out_data.has_char, out_data.out_char, out_data.token_end,
                 out_data.line_done, out_data.error, out_data.last);
      end else begin
        want = expected_results.pop_front();
        if (out_data !== want) begin
          mismatches++;
          $display("%0t: expected has_char=%b char=%h end=%b done=%b err=%b last=%b, %s",
                   $time, want.has_char, want.out_char, want.token_end, want.line_done,
                   want.error, want.last,
                   $sformatf("got has_char=%b char=%h end=%b done=%b err=%b last=%b",
                             out_data.has_char, out_data.out_char, out_data.token_end,
                             out_data.line_done, out_data.error, out_data.last));
        end
      end
    end
    out_ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  initial begin
    repeat (4) @(posedge clk);
    rst        <= 1'b0;
    tok_mode   = MODE_IDLE;
    tok_escape = 1'b0;
    @(posedge clk);
    test_directed();
    test_random_lines(420);
    test_back_to_back(160);
    test_noise(100);
    test_drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule
